/* hw/rtl/cfr_pkg.sv */
// Shared types and constants for the CRC-8 framed packet receiver.
// No dependencies; the other files of the block, apart from cfr_if, refer to it by scoped names.
`timescale 1ns / 1ps

package cfr_pkg;

    localparam int FRAME_LEN = 15;
    localparam int LAST_IDX  = FRAME_LEN - 1;
    localparam int CNT_W     = $clog2(FRAME_LEN);

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    localparam logic [15:0] FADER_SPAN = 16'd16383;
    localparam logic [11:0] MOTOR_MAX  = 12'd4095;

    // configuration register indexes
    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_OWN_ID     = 2'd1;
    localparam logic [1:0] CFG_IDLE_TMO   = 2'd2;

    localparam logic [7:0] RST_START_BYTE = 8'hAA;
    localparam logic [7:0] RST_OWN_ID     = 8'h01;
    localparam logic [7:0] RST_IDLE_TMO   = 8'd5;

    localparam logic       MODE_BYTE = 1'b0;
    localparam logic       MODE_TICK = 1'b1;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] own_id;
        logic [7:0] idle_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic        ok;
        logic [55:0] track_name;
        logic [7:0]  flags;
        logic [15:0] fader_target;
        logic [7:0]  vu_level;
        logic [7:0]  connected;
    } t_frame;

endpackage

/* hw/rtl/cfr_if.sv */
// Handshake channels of the packet receiver: received items in, decoded frames out.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

interface cfr_rx_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface cfr_res_if;
    logic        valid;
    logic        ready;
    logic [55:0] track_name;
    logic [7:0]  flags;
    logic [15:0] fader_target;
    logic [11:0] motor_target;
    logic [7:0]  vu_level;
    logic [7:0]  connected;

    modport source (output valid, output track_name, output flags, output fader_target,
                    output motor_target, output vu_level, output connected, input ready);
    modport sink   (input valid, input track_name, input flags, input fader_target,
                    input motor_target, input vu_level, input connected, output ready);
endinterface

/* hw/rtl/cfr_cfg_regs.sv */
// Configuration registers: start byte, own slave id and idle timeout.
// Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    output cfr_pkg::t_cfg     o_cfg
);

    cfr_pkg::t_cfg r_cfg;
    cfr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                cfr_pkg::CFG_START_BYTE: n_cfg.start_byte      = i_cfg_data;
                cfr_pkg::CFG_OWN_ID:     n_cfg.own_id          = i_cfg_data;
                cfr_pkg::CFG_IDLE_TMO:   n_cfg.idle_timeout_ms = i_cfg_data;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte      <= cfr_pkg::RST_START_BYTE;
            r_cfg.own_id          <= cfr_pkg::RST_OWN_ID;
            r_cfg.idle_timeout_ms <= cfr_pkg::RST_IDLE_TMO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/cfr_frame_ctrl.sv */
// Frame hunter and collector: byte counter, running CRC-8, idle timer, frame store.
// Depends on cfr_pkg; flags a checked frame in the cycle its last byte is taken.
`timescale 1ns / 1ps

module cfr_frame_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_mode,
    input  logic [7:0]        i_rx_byte,
    input  cfr_pkg::t_cfg     i_cfg,
    output cfr_pkg::t_frame   o_frame
);

    localparam int CW = cfr_pkg::CNT_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_crc;
    logic [7:0]    n_crc;
    logic [7:0]    r_idle;
    logic [7:0]    n_idle;
    logic          n_store_we;
    logic          n_ok;
    logic [7:0]    r_store [cfr_pkg::FRAME_LEN];
    logic [7:0]    crc_base;
    logic [7:0]    crc_next;
    logic [7:0]    idle_inc;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & cfr_pkg::CRC_MSB) != 8'd0) begin
                c = {c[6:0], 1'b0} ^ cfr_pkg::CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign crc_base = (r_count == '0) ? 8'd0 : r_crc;
    assign crc_next = crc_feed(crc_base, i_rx_byte);
    assign idle_inc = (r_idle == 8'hFF) ? r_idle : r_idle + 8'd1;

    always_comb begin
        n_count    = r_count;
        n_crc      = r_crc;
        n_idle     = r_idle;
        n_store_we = 1'b0;
        n_ok       = 1'b0;
        if (i_take) begin
            if (i_mode == cfr_pkg::MODE_TICK) begin
                n_idle = idle_inc;
                // drop a partial frame that has gone quiet too long
                if (r_count != '0 && idle_inc > i_cfg.idle_timeout_ms) begin
                    n_count = '0;
                end
            end else begin
                n_idle = 8'd0;
                if (r_count != '0 || i_rx_byte == i_cfg.start_byte) begin
                    n_store_we = 1'b1;
                    if (r_count != CW'(cfr_pkg::LAST_IDX)) begin
                        n_crc   = crc_next;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_count = '0;
                        n_ok    = (r_crc == i_rx_byte) && (r_store[1] == i_cfg.own_id);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= 8'd0;
            r_idle  <= 8'd0;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_idle  <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_store_we) begin
            r_store[r_count] <= i_rx_byte;
        end
    end

    assign o_frame.ok           = n_ok;
    assign o_frame.track_name   = {r_store[8], r_store[7], r_store[6], r_store[5],
                                   r_store[4], r_store[3], r_store[2]};
    assign o_frame.flags        = r_store[9];
    assign o_frame.fader_target = {r_store[11], r_store[10]};
    assign o_frame.vu_level     = r_store[12];
    assign o_frame.connected    = r_store[13];

endmodule

/* hw/rtl/cfr_motor_scale.sv */
// Maps the raw fader target onto the motor range: target*4095/16383, saturated.
// Depends on cfr_pkg. Division by 2^14-1 is a shift plus one correction step.
`timescale 1ns / 1ps

module cfr_motor_scale (
    input  logic [15:0] i_fader,
    output logic [11:0] o_motor
);

    logic [13:0] f14;
    logic [25:0] prod;
    logic [11:0] q0;
    logic [14:0] rem;
    logic [11:0] q;

    // f*4095 = f*4096 - f; below the span it fits in 26 bits
    assign f14  = i_fader[13:0];
    assign prod = {f14, 12'd0} - {12'd0, f14};
    assign q0   = prod[25:14];
    // remainder against 2^14-1 is low part plus quotient guess, below twice the span
    assign rem  = {1'b0, prod[13:0]} + {3'd0, q0};
    assign q    = (rem >= cfr_pkg::FADER_SPAN[14:0]) ? q0 + 12'd1 : q0;

    assign o_motor = (i_fader >= cfr_pkg::FADER_SPAN) ? cfr_pkg::MOTOR_MAX : q;

endmodule

/* hw/rtl/crc8_framed_packet_receiver.sv */
// CRC-8 framed packet receiver, top level.
// Takes a stream of received bytes and millisecond ticks on i_rx (mode 0 byte,
// mode 1 tick) and hands each checked 15-byte frame out on o_res.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 start byte, 1 own slave id, 2 idle timeout in ticks); other indexes are
// ignored. Write only while no frame result is pending.
// Throughput: one item per cycle while i_rx.ready is high. Each item updates the byte counter, running
// CRC and idle timer in the cycle it is accepted.
// Result: the result of a frame is valid on o_res in the cycle after its final
// byte is accepted; frames failing the CRC or id check give no result.
// Stall: a result waits in the output register; i_rx.ready stays high while
// the register is empty or is being taken, so a stalled receiver blocks input
// only while a result sits unclaimed.
// Reset (synchronous, i_rst_n low): configuration returns to 0xAA, 1 and 5,
// any partial frame is dropped and the output register is emptied.
// Depends on cfr_pkg, cfr_if, cfr_cfg_regs, cfr_frame_ctrl and cfr_motor_scale.
`timescale 1ns / 1ps

module crc8_framed_packet_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    cfr_rx_if.sink      i_rx,
    cfr_res_if.source   o_res
);

    cfr_pkg::t_cfg   cfg;
    cfr_pkg::t_frame frame;
    logic            take;
    logic [11:0]     motor;

    logic            r_valid;
    logic            n_valid;
    logic [55:0]     r_track_name;
    logic [7:0]      r_flags;
    logic [15:0]     r_fader;
    logic [11:0]     r_motor;
    logic [7:0]      r_vu;
    logic [7:0]      r_conn;

    assign i_rx.ready = !r_valid || o_res.ready;
    assign take       = i_rx.valid && i_rx.ready;

    cfr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cfr_frame_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_mode    (i_rx.mode),
        .i_rx_byte (i_rx.rx_byte),
        .i_cfg     (cfg),
        .o_frame   (frame)
    );

    cfr_motor_scale u_scale (
        .i_fader (frame.fader_target),
        .o_motor (motor)
    );

    always_comb begin
        n_valid = r_valid;
        if (frame.ok) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // load the result register only when a frame passes both checks
    always_ff @(posedge i_clk) begin
        if (frame.ok) begin
            r_track_name <= frame.track_name;
            r_flags      <= frame.flags;
            r_fader      <= frame.fader_target;
            r_motor      <= motor;
            r_vu         <= frame.vu_level;
            r_conn       <= frame.connected;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.track_name   = r_track_name;
    assign o_res.flags        = r_flags;
    assign o_res.fader_target = r_fader;
    assign o_res.motor_target = r_motor;
    assign o_res.vu_level     = r_vu;
    assign o_res.connected    = r_conn;

endmodule

/* bench/cfr_frame_checker.sv */
// Frame checker for the packet receiver: tracks the configuration writes, predicts
// each decoded frame from the accepted items and compares it with o_res.
// Depends on cfr_pkg and the cfr_rx_if / cfr_res_if channels.
`timescale 1ns / 1ps

module cfr_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    cfr_rx_if          i_rx,
    cfr_res_if         i_res,
    output int         o_fail_count,
    output int         o_frames_pending
);

    typedef struct packed {
        logic [55:0] track_name;
        logic [7:0]  flags;
        logic [15:0] fader_target;
        logic [11:0] motor_target;
        logic [7:0]  vu_level;
        logic [7:0]  connected;
    } t_frame_result;

    t_frame_result frames_due[$];

    logic [7:0]                start_sel;
    logic [7:0]                slave_id;
    logic [7:0]                tmo_limit;
    logic [cfr_pkg::CNT_W-1:0] bytes_held;
    logic [7:0]                crc_acc;
    logic [7:0]                frame_buf [cfr_pkg::FRAME_LEN];
    logic [7:0]                ticks_idle;
    int                        mismatches;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = (c << 1) ^ cfr_pkg::CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    // advance the deframer by one item; queue the frame it completes, if any
    task automatic absorb_item(input logic mode, input logic [7:0] b);
        t_frame_result r;
        int unsigned   fader32;
        int unsigned   scaled;
        if (mode == cfr_pkg::MODE_TICK) begin
            if (ticks_idle != 8'hFF) begin
                ticks_idle = ticks_idle + 8'd1;
            end
            if (bytes_held != 0 && ticks_idle > tmo_limit) begin
                bytes_held = '0;
            end
        end else begin
            ticks_idle = '0;
            if (bytes_held != 0 || b == start_sel) begin
                if (bytes_held == 0) begin
                    crc_acc = '0;
                end
                frame_buf[bytes_held] = b;
                if (bytes_held < cfr_pkg::LAST_IDX) begin
                    crc_acc    = crc8_next(crc_acc, b);
                    bytes_held = bytes_held + 1'b1;
                end else begin
                    bytes_held = '0;
                    if (crc_acc == b && frame_buf[1] == slave_id) begin
                        for (int i = 0; i < 7; i++) begin
                            r.track_name[8*i +: 8] = frame_buf[2+i];
                        end
                        r.flags        = frame_buf[9];
                        r.fader_target = {frame_buf[11], frame_buf[10]};
                        fader32        = r.fader_target;
                        scaled         = fader32 * cfr_pkg::MOTOR_MAX / cfr_pkg::FADER_SPAN;
                        r.motor_target = (scaled > cfr_pkg::MOTOR_MAX) ?
                                         cfr_pkg::MOTOR_MAX : scaled[11:0];
                        r.vu_level     = frame_buf[12];
                        r.connected    = frame_buf[13];
                        frames_due.push_back(r);
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string field, input logic [55:0] want,
                               input logic [55:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            start_sel  = cfr_pkg::RST_START_BYTE;
            slave_id   = cfr_pkg::RST_OWN_ID;
            tmo_limit  = cfr_pkg::RST_IDLE_TMO;
            bytes_held = '0;
            crc_acc    = '0;
            ticks_idle = '0;
            mismatches = 0;
            frames_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (frames_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected frame, expected none, actual name %h fader %h",
                             $time, i_res.track_name, i_res.fader_target);
                end else begin
                    want = frames_due.pop_front();
                    check_field("track_name", want.track_name, i_res.track_name);
                    check_field("flags", 56'(want.flags), 56'(i_res.flags));
                    check_field("fader_target", 56'(want.fader_target),
                                56'(i_res.fader_target));
                    check_field("motor_target", 56'(want.motor_target),
                                56'(i_res.motor_target));
                    check_field("vu_level", 56'(want.vu_level), 56'(i_res.vu_level));
                    check_field("connected", 56'(want.connected), 56'(i_res.connected));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cfr_pkg::CFG_START_BYTE: start_sel = i_cfg_data;
                    cfr_pkg::CFG_OWN_ID:     slave_id  = i_cfg_data;
                    cfr_pkg::CFG_IDLE_TMO:   tmo_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx.valid && i_rx.ready) begin
                absorb_item(i_rx.mode, i_rx.rx_byte);
            end
        end
        o_fail_count     <= mismatches;
        o_frames_pending <= frames_due.size();
    end

endmodule

/* bench/tb_top.sv */
// Testbench top for crc8_framed_packet_receiver: drives bytes, ticks and register
// writes through phases of sender idling and receiver stalls; gives the verdict.
// Depends on cfr_pkg, cfr_if, the block and cfr_frame_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_ITEMS = 400;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    int         chk_fails;
    int         chk_pending;

    cfr_rx_if  rx_ch ();
    cfr_res_if res_ch ();

    crc8_framed_packet_receiver u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_ch),
        .o_res      (res_ch)
    );

    cfr_frame_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_rx             (rx_ch),
        .i_res            (res_ch),
        .o_fail_count     (chk_fails),
        .o_frames_pending (chk_pending)
    );

    int         sender_idle_pct;
    int         recv_stall_pct;
    int         items_sent;
    logic [7:0] cur_start;
    logic [7:0] cur_id;
    logic [7:0] cur_tmo;
    logic [7:0] pkt [cfr_pkg::FRAME_LEN];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_item(input logic mode, input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.mode    <= mode;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic push_tick();
        push_item(cfr_pkg::MODE_TICK, 8'($urandom_range(255)));
    endtask

    // append the CRC over bytes 0..13
    task automatic seal_packet();
        logic [7:0] c;
        c = '0;
        for (int i = 0; i < cfr_pkg::LAST_IDX; i++) begin
            c = c ^ pkt[i];
            for (int k = 0; k < 8; k++) begin
                c = c[7] ? ((c << 1) ^ cfr_pkg::CRC_POLY) : (c << 1);
            end
        end
        pkt[cfr_pkg::LAST_IDX] = c;
    endtask

    task automatic build_frame(input logic [7:0] id);
        pkt[0] = cur_start;
        pkt[1] = id;
        for (int i = 2; i < cfr_pkg::LAST_IDX; i++) begin
            pkt[i] = ($urandom_range(19) == 0) ? cur_start : 8'($urandom_range(255));
        end
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
                0: {pkt[11], pkt[10]} = 16'hFFFF;
                1: {pkt[11], pkt[10]} = 16'h3FFF;
                2: {pkt[11], pkt[10]} = 16'h4000;
                3: {pkt[11], pkt[10]} = 16'h3FFE;
                default: {pkt[11], pkt[10]} = 16'h0000;
            endcase
        end
        seal_packet();
    endtask

    // send the first n bytes; a lone tick between bytes stays within any nonzero timeout
    task automatic send_packet(input int n);
        for (int i = 0; i < n; i++) begin
            if (cur_tmo != 0 && $urandom_range(29) == 0) begin
                push_tick();
            end
            push_item(cfr_pkg::MODE_BYTE, pkt[i]);
        end
    endtask

    // hold the sender until every decoded frame is out and the block is quiet
    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            cfr_pkg::CFG_START_BYTE: cur_start = data;
            cfr_pkg::CFG_OWN_ID:     cur_id    = data;
            cfr_pkg::CFG_IDLE_TMO:   cur_tmo   = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] start, input logic [7:0] id,
                              input logic [7:0] tmo);
        write_reg(cfr_pkg::CFG_START_BYTE, start);
        write_reg(cfr_pkg::CFG_OWN_ID, id);
        write_reg(cfr_pkg::CFG_IDLE_TMO, tmo);
    endtask

    // mostly well-formed frames, the rest bad CRC, wrong id, cut short or stray items
    task automatic run_random(input int target);
        int         sel;
        int         bit_no;
        logic [7:0] id;
        while (items_sent < target) begin
            sel = $urandom_range(99);
            if (sel < 84) begin
                id = cur_id;
                if (sel >= 76) begin
                    id = 8'($urandom_range(255, 1));
                    id = id ^ cur_id;
                end
                build_frame(id);
                if (sel >= 70 && sel < 76) begin
                    bit_no = $urandom_range(7);
                    pkt[cfr_pkg::LAST_IDX][bit_no] = ~pkt[cfr_pkg::LAST_IDX][bit_no];
                end
                send_packet(cfr_pkg::FRAME_LEN);
            end else if (sel < 90) begin
                build_frame(cur_id);
                send_packet($urandom_range(cfr_pkg::LAST_IDX, 1));
                if (cur_tmo < 10) begin
                    repeat (cur_tmo + 1) push_tick();
                end
            end else if (sel < 96) begin
                push_item(cfr_pkg::MODE_BYTE, 8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(3, 1)) push_tick();
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= cfr_pkg::CFG_START_BYTE;
        i_cfg_data      <= '0;
        rx_ch.valid     <= 1'b0;
        rx_ch.mode      <= cfr_pkg::MODE_BYTE;
        rx_ch.rx_byte   <= '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        items_sent      = 0;
        cur_start       = cfr_pkg::RST_START_BYTE;
        cur_id          = cfr_pkg::RST_OWN_ID;
        cur_tmo         = cfr_pkg::RST_IDLE_TMO;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stray byte while hunting, a tick, one frame with start byte
        // in its data and a saturating fader, then a partial frame left to time out
        push_item(cfr_pkg::MODE_BYTE, 8'h00);
        push_item(cfr_pkg::MODE_TICK, 8'hFF);
        pkt[0]  = cfr_pkg::RST_START_BYTE;
        pkt[1]  = cfr_pkg::RST_OWN_ID;
        pkt[2]  = 8'h00;
        pkt[3]  = 8'hFF;
        pkt[4]  = cfr_pkg::RST_START_BYTE;
        pkt[5]  = 8'h80;
        pkt[6]  = 8'h7F;
        pkt[7]  = 8'h01;
        pkt[8]  = 8'hFE;
        pkt[9]  = 8'hFF;
        pkt[10] = 8'hFF;
        pkt[11] = 8'hFF;
        pkt[12] = 8'h00;
        pkt[13] = 8'hFF;
        seal_packet();
        send_packet(cfr_pkg::FRAME_LEN);
        push_item(cfr_pkg::MODE_BYTE, cfr_pkg::RST_START_BYTE);
        push_item(cfr_pkg::MODE_BYTE, cfr_pkg::RST_OWN_ID);
        push_item(cfr_pkg::MODE_BYTE, 8'h42);
        repeat (cfr_pkg::RST_IDLE_TMO + 1) push_tick();
        settle();

        // phase: no idling, low extremes, unused index poked
        set_config(8'h00, 8'hFF, 8'h00);
        write_reg(CFG_UNUSED, 8'h5A);
        run_random(items_sent + PHASE_ITEMS);
        settle();

        // phase: sender idling, high extremes; finish with a partial frame
        // held across enough ticks to saturate the idle counter
        set_config(8'hFF, 8'h00, 8'hFF);
        sender_idle_pct = 71;
        run_random(items_sent + PHASE_ITEMS);
        build_frame(cur_id);
        send_packet(3);
        repeat (260) push_tick();
        settle();

        // phase: receiver stalling; the first tick must drop the held frame
        set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd1);
        sender_idle_pct = 0;
        recv_stall_pct  = 71;
        push_tick();
        run_random(items_sent + PHASE_ITEMS);
        settle();

        // phase: both sides idling
        set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(20, 2)));
        sender_idle_pct = 29;
        recv_stall_pct  = 29;
        run_random(items_sent + PHASE_ITEMS);
        settle();

        if (chk_fails == 0 && chk_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
